@@ design/counting_semaphore_bank_defines.svh @@
// assertion macros for the counting semaphore bank
`ifndef COUNTING_SEMAPHORE_BANK_DEFINES_SVH
`define COUNTING_SEMAPHORE_BANK_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define CSB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define CSB_ASSERT(lbl, prop, msg) \
  `CSB_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ design/csb_pkg.sv @@
// types and constants shared by the counting semaphore bank
`default_nettype none

package csb_pkg;

  localparam int NumSem     = 1024;
  localparam int IdxW       = $clog2(NumSem);
  localparam int ProcBits   = 8;
  localparam int IndexBits  = 12;
  localparam int GenShift   = 12;
  localparam int CountW     = 32;
  localparam int HandleW    = 32;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_WAIT    = 2'd2,
    OP_SIGNAL  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNAVAIL = 3'd3,
    ST_BLOCK   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LINK
  } state_e;

  typedef struct packed {
    op_e                      op;
    logic [HandleW-1:0]       sem_handle;
    logic [7:0]               caller_process;
    logic signed [CountW-1:0] limit_count;
    logic signed [CountW-1:0] start_count;
    logic                     try_only;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] new_handle;
    logic               wake_one;
    logic               wake_all;
  } out_item_t;

  // free list link of one entry
  typedef struct packed {
    logic            ok;
    logic [IdxW-1:0] idx;
  } link_t;

  // semaphore record of one entry
  typedef struct packed {
    logic [ProcBits-1:0]      owner;
    logic signed [CountW-1:0] max_cnt;
    logic signed [CountW-1:0] cur_cnt;
  } sem_ent_t;

  localparam int LinkW = $bits(link_t);
  localparam int SemW  = $bits(sem_ent_t);

  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    link_t           wdata;
  } link_req_t;

  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    sem_ent_t        wdata;
  } sem_req_t;

endpackage

`default_nettype wire

@@ design/counting_semaphore_bank.sv @@
// top level of the counting semaphore bank
//
// usage
// - one command channel (in_valid_i / in_ready_o / in_item_i) carries create,
//   destroy, wait and signal items; one result channel (out_valid_o /
//   out_ready_i / out_item_o) returns exactly one result item per command
// - state sits in two rams with registered read: the free list links and the
//   per-entry record (owner, maximum, count); free list head, tail and the
//   generation counter are flops
// - an item is accepted, the rams are read in that same cycle, and the next
//   cycle checks the owner, updates the record and loads the result register
// - one item at a time: create, wait and signal pass through the exec state; a
//   valid destroy also passes the link state, since it writes up to two links
//   through the single write port of the link ram
// - after reset a clearing pass over all 1024 entries builds the initial free list
//   (0 -> 1 -> ... -> 1023); no item is accepted during it
// - a stalled receiver holds the result register; the next item is taken only
//   once that register is empty or being drained in the same cycle
`default_nettype none

`include "counting_semaphore_bank_defines.svh"

module counting_semaphore_bank
  import csb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  link_req_t link_req;
  link_t     link_rdata;
  sem_req_t  sem_req;
  sem_ent_t  sem_rdata;

  // sequencer and free list pointers
  csb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o),
    .link_req_o   (link_req),
    .link_rdata_i (link_rdata),
    .sem_req_o    (sem_req),
    .sem_rdata_i  (sem_rdata)
  );

  // free list successor links
  csb_ram #(
    .Width (LinkW),
    .Depth (NumSem)
  ) u_link_ram (
    .clk_i   (clk_i),
    .re_i    (link_req.re),
    .raddr_i (link_req.raddr),
    .we_i    (link_req.we),
    .waddr_i (link_req.waddr),
    .wdata_i (link_req.wdata),
    .rdata_o (link_rdata)
  );

  // semaphore records, owner is only meaningful once created
  csb_ram #(
    .Width (SemW),
    .Depth (NumSem)
  ) u_sem_ram (
    .clk_i   (clk_i),
    .re_i    (sem_req.re),
    .raddr_i (sem_req.raddr),
    .we_i    (sem_req.we),
    .waddr_i (sem_req.waddr),
    .wdata_i (sem_req.wdata),
    .rdata_o (sem_rdata)
  );

  // one item in flight: no acceptance right after one
  `CSB_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o,
              "item accepted while another is in flight")

  // table writes never overlap an acceptance and its reads
  `CSB_ASSERT(a_no_write_on_accept,
              (link_req.we || sem_req.we) |-> !(in_valid_i && in_ready_o),
              "ram write in an acceptance cycle")

  // signal and destroy never report together
  `CSB_ASSERT(a_wake_exclusive,
              out_valid_o |-> !(out_item_o.wake_one && out_item_o.wake_all),
              "both wake requests raised")

  // a nonzero handle only comes with a successful create
  `CSB_ASSERT(a_handle_ok,
              (out_valid_o && (out_item_o.new_handle != '0)) |->
              (out_item_o.status == ST_OK),
              "handle returned with failing status")

endmodule

`default_nettype wire

@@ design/csb_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none

module csb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/csb_ctrl.sv @@
// sequencer: free list pointers, read-modify-write of the tables, result register
`default_nettype none

module csb_ctrl
  import csb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o,
  output link_req_t      link_req_o,
  input  wire link_t     link_rdata_i,
  output sem_req_t       sem_req_o,
  input  wire sem_ent_t  sem_rdata_i
);

  state_e             state_q, state_d;
  logic [IdxW-1:0]    clr_q, clr_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic               head_ok_q, head_ok_d;
  logic [IdxW-1:0]    tail_q, tail_d;
  logic               tail_ok_q, tail_ok_d;
  logic [HandleW-1:0] total_q, total_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;
  in_item_t           item_q, item_d;
  logic               idx_ok_q, idx_ok_d;

  logic               accept;
  logic [IdxW-1:0]    item_idx;
  logic               lookup_ok;
  logic [HandleW-1:0] total_inc;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign item_idx   = item_q.sem_handle[IdxW-1:0];
  assign lookup_ok  = idx_ok_q &&
                      (sem_rdata_i.owner == item_q.caller_process[ProcBits-1:0]);
  assign total_inc  = total_q + HandleW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == IdxW'(NumSem - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((item_q.op == OP_DESTROY) && lookup_ok) begin
          state_d = S_LINK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LINK: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    clr_d       = clr_q;
    head_d      = head_q;
    head_ok_d   = head_ok_q;
    tail_d      = tail_q;
    tail_ok_d   = tail_ok_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    item_d      = item_q;
    idx_ok_d    = idx_ok_q;
    link_req_o  = '0;
    sem_req_o   = '0;

    if (accept) begin
      item_d            = in_item_i;
      idx_ok_d          = {1'b0, in_item_i.sem_handle[IndexBits-1:0]} <
                          (IndexBits + 1)'(NumSem);
      link_req_o.re     = 1'b1;
      link_req_o.raddr  = head_q;
      sem_req_o.re      = 1'b1;
      sem_req_o.raddr   = in_item_i.sem_handle[IdxW-1:0];
    end

    case (state_q)
      S_CLEAR: begin
        // link every entry to its successor, last one has none
        link_req_o.we        = 1'b1;
        link_req_o.waddr     = clr_q;
        link_req_o.wdata.ok  = (clr_q != IdxW'(NumSem - 1));
        link_req_o.wdata.idx = clr_q + IdxW'(1);
        clr_d                = clr_q + IdxW'(1);
      end
      S_EXEC: begin
        out_valid_d           = 1'b1;
        out_item_d.status     = ST_OK;
        out_item_d.new_handle = '0;
        out_item_d.wake_one   = 1'b0;
        out_item_d.wake_all   = 1'b0;
        if (item_q.op == OP_CREATE) begin
          if (!head_ok_q) begin
            out_item_d.status = ST_FULL;
          end else begin
            if (link_rdata_i.ok) begin
              head_d = link_rdata_i.idx;
            end else begin
              head_ok_d = 1'b0;
              tail_ok_d = 1'b0;
            end
            link_req_o.we          = 1'b1;
            link_req_o.waddr       = head_q;
            link_req_o.wdata       = '0;
            total_d                = total_inc;
            out_item_d.new_handle  = (total_inc << GenShift) | HandleW'(head_q);
            sem_req_o.we           = 1'b1;
            sem_req_o.waddr        = head_q;
            sem_req_o.wdata.owner  = item_q.caller_process[ProcBits-1:0];
            sem_req_o.wdata.max_cnt = item_q.limit_count;
            sem_req_o.wdata.cur_cnt = item_q.start_count;
          end
        end else if (!lookup_ok) begin
          out_item_d.status = ST_INVALID;
        end else begin
          case (item_q.op)
            OP_DESTROY: begin
              // clear counts, hang entry behind the old tail
              sem_req_o.we            = 1'b1;
              sem_req_o.waddr         = item_idx;
              sem_req_o.wdata.owner   = sem_rdata_i.owner;
              sem_req_o.wdata.max_cnt = '0;
              sem_req_o.wdata.cur_cnt = '0;
              if (tail_ok_q) begin
                link_req_o.we        = 1'b1;
                link_req_o.waddr     = tail_q;
                link_req_o.wdata.ok  = 1'b1;
                link_req_o.wdata.idx = item_idx;
              end
              tail_d    = item_idx;
              tail_ok_d = 1'b1;
              if (!head_ok_q) begin
                head_d    = item_idx;
                head_ok_d = 1'b1;
              end
              out_item_d.status   = ST_INVALID;
              out_item_d.wake_all = 1'b1;
            end
            OP_WAIT: begin
              if ($signed(sem_rdata_i.cur_cnt) <= $signed(CountW'(0))) begin
                out_item_d.status = item_q.try_only ? ST_UNAVAIL : ST_BLOCK;
              end else begin
                sem_req_o.we            = 1'b1;
                sem_req_o.waddr         = item_idx;
                sem_req_o.wdata         = sem_rdata_i;
                sem_req_o.wdata.cur_cnt = sem_rdata_i.cur_cnt - CountW'(1);
              end
            end
            default: begin
              if ($signed(sem_rdata_i.cur_cnt) < $signed(sem_rdata_i.max_cnt)) begin
                sem_req_o.we            = 1'b1;
                sem_req_o.waddr         = item_idx;
                sem_req_o.wdata         = sem_rdata_i;
                sem_req_o.wdata.cur_cnt = sem_rdata_i.cur_cnt + CountW'(1);
              end
              out_item_d.wake_one = 1'b1;
            end
          endcase
        end
      end
      S_LINK: begin
        // destroyed entry becomes the end of the list
        link_req_o.we    = 1'b1;
        link_req_o.waddr = item_idx;
        link_req_o.wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      head_ok_q   <= 1'b1;
      tail_q      <= IdxW'(NumSem - 1);
      tail_ok_q   <= 1'b1;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      head_ok_q   <= head_ok_d;
      tail_q      <= tail_d;
      tail_ok_q   <= tail_ok_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    idx_ok_q   <= idx_ok_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

@@ test/csb_checker.sv @@
`timescale 1ns / 100ps
// reply predictor and scoreboard for the counting semaphore bank
module csb_checker
  import csb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  logic      cmd_ready_i,
  input  in_item_t  cmd_item_i,
  input  logic      res_valid_i,
  input  logic      res_ready_i,
  input  out_item_t res_item_i,
  output int        mismatches_o,
  output int        pending_o
);

  // predicted bank state; back links are never read, so only forward links kept
  logic [IdxW-1:0]          head_q;
  logic [IdxW-1:0]          tail_q;
  logic                     head_ok_q;
  logic                     tail_ok_q;
  logic [IdxW-1:0]          succ_idx [NumSem];
  logic                     succ_ok  [NumSem];
  logic signed [CountW-1:0] cnt      [NumSem];
  logic signed [CountW-1:0] cap      [NumSem];
  logic [ProcBits-1:0]      owner_q  [NumSem];
  logic [31:0]              gen_q;

  out_item_t owed_q[$];
  out_item_t want;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("%0t mismatch on %s: got %0h, predicted %0h", $time, what, got, exp_val);
    mismatches_o++;
  endtask

  // runs one command against the predicted state and returns its reply
  task automatic apply_command(input in_item_t c, output out_item_t r);
    logic [IndexBits-1:0] slot;
    logic [IdxW-1:0]      e;
    r = '0;
    r.status = ST_OK;
    if (c.op == OP_CREATE) begin
      if (!head_ok_q) begin
        r.status = ST_FULL;
      end else begin
        e = head_q;
        if (succ_ok[e]) begin
          head_q = succ_idx[e];
        end else begin
          head_ok_q = 1'b0;
          tail_ok_q = 1'b0;
        end
        succ_ok[e] = 1'b0;
        gen_q = gen_q + 32'd1;
        r.new_handle = HandleW'(e) | (gen_q << GenShift);
        cnt[e] = c.start_count;
        cap[e] = c.limit_count;
        owner_q[e] = c.caller_process[ProcBits-1:0];
      end
    end else begin
      slot = c.sem_handle[IndexBits-1:0];
      e = slot[IdxW-1:0];
      if (int'(slot) >= NumSem) begin
        r.status = ST_INVALID;
      end else if (owner_q[e] != c.caller_process[ProcBits-1:0]) begin
        r.status = ST_INVALID;
      end else begin
        case (c.op)
          OP_DESTROY: begin
            cnt[e] = '0;
            cap[e] = '0;
            if (tail_ok_q) begin
              succ_idx[tail_q] = e;
              succ_ok[tail_q] = 1'b1;
            end
            succ_ok[e] = 1'b0;
            tail_q = e;
            tail_ok_q = 1'b1;
            if (!head_ok_q) begin
              head_q = e;
              head_ok_q = 1'b1;
            end
            r.wake_all = 1'b1;
            r.status = ST_INVALID;
          end
          OP_WAIT: begin
            if (cnt[e] <= 0) r.status = c.try_only ? ST_UNAVAIL : ST_BLOCK;
            else cnt[e] = cnt[e] - 1;
          end
          default: begin
            if (cnt[e] < cap[e]) cnt[e] = cnt[e] + 1;
            r.wake_one = 1'b1;
          end
        endcase
      end
    end
  endtask

  // sampled on the falling edge: the values seen here decide the next rising edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSem; i++) begin
        succ_idx[i] = IdxW'(i + 1);
        succ_ok[i] = (i + 1 < NumSem);
        cnt[i] = '0;
        cap[i] = '0;
        owner_q[i] = '0;
      end
      head_q = '0;
      tail_q = IdxW'(NumSem - 1);
      head_ok_q = 1'b1;
      tail_ok_q = 1'b1;
      gen_q = '0;
      owed_q.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      // replies first: a reply never belongs to a command taken on the same edge
      if (res_valid_i && res_ready_i) begin
        if (owed_q.size() == 0) begin
          note_mismatch("reply with none pending", res_item_i.new_handle, '0);
        end else begin
          want = owed_q.pop_front();
          if (res_item_i.status !== want.status)
            note_mismatch("status", res_item_i.status, want.status);
          if (res_item_i.new_handle !== want.new_handle)
            note_mismatch("new_handle", res_item_i.new_handle, want.new_handle);
          if (res_item_i.wake_one !== want.wake_one)
            note_mismatch("wake_one", res_item_i.wake_one, want.wake_one);
          if (res_item_i.wake_all !== want.wake_all)
            note_mismatch("wake_all", res_item_i.wake_all, want.wake_all);
        end
      end
      if (cmd_valid_i && cmd_ready_i) begin
        apply_command(cmd_item_i, want);
        owed_q.push_back(want);
      end
      pending_o = owed_q.size();
    end
  end

endmodule

@@ test/tb_counting_semaphore_bank.sv @@
`timescale 1ns / 100ps
// stimulus, flow control and verdict for the counting semaphore bank
module tb_counting_semaphore_bank;
  import csb_pkg::*;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  int mismatches;
  int pending;

  // stimulus bookkeeping, learned from replies: which entries a create has
  // written (only those may be addressed in range) and who owns them
  logic [7:0] caller_q[$];
  bit         known[NumSem];
  logic [7:0] owner_of[NumSem];
  int         known_list[$];
  bit         table_full_seen;
  int         results_seen;
  int         op_tally[4];
  int         st_tally[8];
  int         sent_count;
  bit         calm_tx;

  counting_semaphore_bank u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  csb_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (in_valid_i),
    .cmd_ready_i  (in_ready_o),
    .cmd_item_i   (in_item_i),
    .res_valid_i  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_item_i   (out_item_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("run timed out");
    $display("tb_counting_semaphore_bank failed");
    $finish;
  end

  // idle length: mostly short, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic in_item_t make_cmd(op_e o, logic [31:0] h, logic [7:0] who,
                                        logic [31:0] lim, logic [31:0] init, logic t);
    in_item_t c;
    c.op = o;
    c.sem_handle = h;
    c.caller_process = who;
    c.limit_count = lim;
    c.start_count = init;
    c.try_only = t;
    return c;
  endfunction

  // creates mostly use small counts so that limits and empty counts get hit
  function automatic in_item_t random_create();
    int r;
    logic [31:0] lim;
    logic [31:0] init;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      lim = $urandom_range(0, 4);
      init = $urandom_range(0, 3);
    end else if (r < 90) begin
      lim = $urandom;
      init = $urandom;
    end else begin
      lim = r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      init = r[1] ? 32'hFFFF_FFFF : 32'h8000_0000;
    end
    return make_cmd(OP_CREATE, $urandom, 8'($urandom), lim, init, 1'($urandom));
  endfunction

  // mostly well-formed use of written entries, some out-of-range or foreign
  // callers; the generation bits of the handle are random since they are ignored
  function automatic in_item_t random_cmd();
    int r;
    int idx;
    logic [31:0] tag;
    logic [7:0] who;
    op_e o;
    r = $urandom_range(0, 99);
    if (r < 15 || known_list.size() == 0) return random_create();
    idx = known_list[$urandom_range(0, known_list.size() - 1)];
    tag = $urandom;
    who = owner_of[idx];
    if (r < 25) begin
      o = OP_DESTROY;
    end else if (r < 56) begin
      o = OP_WAIT;
    end else if (r < 90) begin
      o = OP_SIGNAL;
    end else begin
      o = op_e'(2'($urandom_range(1, 3)));
      if (r < 95) idx = $urandom_range(NumSem, (1 << IndexBits) - 1);
      else who = who ^ 8'($urandom_range(1, 255));
    end
    return make_cmd(o, (tag << IndexBits) | 32'(idx), who, $urandom, $urandom,
                    1'($urandom));
  endfunction

  // offer one item and hold it until taken; ready is looked at on the falling
  // edge, where it already shows what the next rising edge will see
  task automatic send_cmd(input in_item_t c);
    int gap;
    gap = 0;
    if (!calm_tx && $urandom_range(0, 99) < 30) gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= c;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    caller_q.push_back(c.caller_process);
    op_tally[c.op]++;
    sent_count++;
    // switch between idling and back-to-back stretches now and then
    if (sent_count % 80 == 0) calm_tx = ($urandom_range(0, 2) == 0);
  endtask

  // learn created entries and their owners from the replies, in order
  always @(negedge clk_i) begin
    logic [7:0] who;
    int idx;
    if (rst_ni && out_valid_o && out_ready_i && caller_q.size() != 0) begin
      who = caller_q.pop_front();
      results_seen++;
      if (out_item_o.status <= ST_BLOCK) st_tally[out_item_o.status]++;
      if (out_item_o.status == ST_FULL) table_full_seen = 1'b1;
      if (out_item_o.status == ST_OK && out_item_o.new_handle != '0) begin
        idx = int'(out_item_o.new_handle[IdxW-1:0]);
        if (!known[idx]) begin
          known[idx] = 1'b1;
          known_list.push_back(idx);
        end
        owner_of[idx] = who;
      end
    end
  end

  // receiver: random stalls, quiet stretches, and one long hold-off while the
  // sender keeps offering so that the result register fills and input stalls
  initial begin : receiver
    int stall_left;
    int hold_left;
    bit held;
    bit calm_rx;
    stall_left = 0;
    hold_left = 0;
    held = 1'b0;
    calm_rx = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 400) begin
        held = 1'b1;
        hold_left = 200;
      end
      if ($urandom_range(0, 99) == 0) calm_rx = !calm_rx;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm_rx && $urandom_range(0, 99) < 35) begin
        stall_left = gap_len() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part; the free list hands out 0, 1, 2, 3 in that order
    // out-of-range index before anything exists
    send_cmd(make_cmd(OP_SIGNAL, 32'h0000_0FFF, 8'h00, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_WAIT, 32'hFFFF_F400, 8'hFF, '1, '1, 1'b1));
    send_cmd(make_cmd(OP_DESTROY, 32'h1234_5C00, 8'h00, '0, '0, 1'b0));
    // entry 0 at the largest count, signal at the maximum, then a wait
    send_cmd(make_cmd(OP_CREATE, 32'hFFFF_FFFF, 8'hFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    send_cmd(make_cmd(OP_SIGNAL, 32'hFFFF_F000, 8'hFF, '0, '0, 1'b1));
    send_cmd(make_cmd(OP_WAIT, 32'h0000_0000, 8'hFF, '0, '0, 1'b0));
    // entry 1 at the smallest count: wait fails both ways, signal at maximum
    send_cmd(make_cmd(OP_CREATE, 32'h0000_0000, 8'h00, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_cmd(make_cmd(OP_WAIT, 32'hABCD_E001, 8'h00, '0, '0, 1'b1));
    send_cmd(make_cmd(OP_WAIT, 32'h0000_0001, 8'h00, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_SIGNAL, 32'h0000_0001, 8'h00, '0, '0, 1'b0));
    // entry 2 with a maximum of one
    send_cmd(make_cmd(OP_CREATE, 32'h0, 8'h5A, 32'd1, 32'd0, 1'b0));
    send_cmd(make_cmd(OP_SIGNAL, 32'h0000_0002, 8'h5A, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_SIGNAL, 32'h0000_0002, 8'h5A, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_WAIT, 32'h0000_0002, 8'h5A, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_WAIT, 32'h0000_0002, 8'h5A, '0, '0, 1'b1));
    // foreign caller, then destroy twice (second one hits a free entry)
    send_cmd(make_cmd(OP_WAIT, 32'h0000_0002, 8'hA5, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_DESTROY, 32'h0000_0002, 8'hA5, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_DESTROY, 32'h0000_0002, 8'h5A, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_DESTROY, 32'h0000_0002, 8'h5A, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_SIGNAL, 32'h0000_0002, 8'h5A, '0, '0, 1'b0));
    // negative start count blocks
    send_cmd(make_cmd(OP_CREATE, 32'h0, 8'h03, 32'd5, 32'hFFFF_FFFF, 1'b0));
    send_cmd(make_cmd(OP_WAIT, 32'h0000_0003, 8'h03, '0, '0, 1'b0));

    // a run of creates to populate the table, stopping early on table full
    for (int n = 0; n < 300 && !table_full_seen; n++) send_cmd(random_create());

    // random mix over the written entries; destroys feed the list again
    repeat (530) send_cmd(random_cmd());

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d commands: %0d create, %0d destroy, %0d wait, %0d signal over %0d entries",
             sent_count, op_tally[OP_CREATE], op_tally[OP_DESTROY], op_tally[OP_WAIT],
             op_tally[OP_SIGNAL], known_list.size());
    $display("replies: %0d ok, %0d invalid, %0d table full, %0d unavailable, %0d would block",
             st_tally[ST_OK], st_tally[ST_INVALID], st_tally[ST_FULL],
             st_tally[ST_UNAVAIL], st_tally[ST_BLOCK]);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_counting_semaphore_bank passed");
    end else begin
      $display("tb_counting_semaphore_bank failed");
    end
    $finish;
  end

endmodule
